/* src/rfs_pkg.sv */
// Shared types and constants for the RGBW fade and strobe engine.
package rfs_pkg;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned SCALE_W = 10;
    localparam int unsigned SPER_W  = 16;
    localparam int unsigned STIME_W = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_PERIOD = 1'b1;
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;
    localparam int unsigned FX_GRADIENT_BIT = 0;
    localparam int unsigned FX_STROBE_BIT   = 1;

    typedef struct packed {
        logic                req_type;
        logic [TIME_W-1:0]   now_ms;
        logic [COLOR_W-1:0]  base_red;
        logic [COLOR_W-1:0]  base_green;
        logic [COLOR_W-1:0]  base_blue;
        logic [COLOR_W-1:0]  base_white;
        logic [COLOR_W-1:0]  goal_red;
        logic [COLOR_W-1:0]  goal_green;
        logic [COLOR_W-1:0]  goal_blue;
        logic [COLOR_W-1:0]  goal_white;
        logic [STIME_W-1:0]  segment_time;
        logic [1:0]          effect_flags;
    } t_req;

    typedef struct packed {
        logic [COLOR_W-1:0] show_red;
        logic [COLOR_W-1:0] show_green;
        logic [COLOR_W-1:0] show_blue;
        logic [COLOR_W-1:0] show_white;
        logic               segment_done;
    } t_rsp;

    // lane control from the top level sequencer
    typedef struct packed {
        logic              load;
        logic              div_start;
        logic              step;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] seg_len;
    } t_lane_ctl;

    typedef struct packed {
        logic div_busy;
        logic at_goal;
        logic pending;
    } t_lane_sts;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction
endpackage

/* src/rfs_if.sv */
// Valid/ready channel interface carrying one payload.
interface rfs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* src/rfs_lane.sv */
// One color channel: step period divider, level and deadline tracking.
module rfs_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rfs_pkg::t_lane_ctl          i_ctl,
    input  logic [rfs_pkg::COLOR_W-1:0] i_base,
    input  logic [rfs_pkg::COLOR_W-1:0] i_goal,
    output logic [rfs_pkg::COLOR_W-1:0] o_level,
    output rfs_pkg::t_lane_sts          o_sts
);
    import rfs_pkg::*;

    logic [COLOR_W-1:0] r_level, r_goal, r_diff;
    logic               r_down;
    logic [TIME_W-1:0]  r_period, r_deadline;
    // restoring divider: quotient shifts into r_period
    logic [TIME_W-1:0]  r_dividend;
    logic [COLOR_W:0]   r_rem;
    logic [5:0]         r_cnt;
    logic               r_busy, r_fix;
    logic [COLOR_W+1:0] n_trial;
    logic [COLOR_W:0]   n_rem_sh;
    logic [COLOR_W-1:0] n_diff;

    always_comb begin
        n_diff   = (i_goal < i_base) ? i_base - i_goal : i_goal - i_base;
        n_rem_sh = {r_rem[COLOR_W-1:0], r_dividend[TIME_W-1]};
        n_trial  = {1'b0, n_rem_sh} - {2'b00, r_diff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0; r_goal <= '0; r_down <= 1'b0; r_diff <= '0;
            r_period <= '0; r_deadline <= '0; r_busy <= 1'b0; r_fix <= 1'b0;
            r_cnt <= '0; r_rem <= '0; r_dividend <= '0;
        end else begin
            r_fix <= !i_ctl.div_start && r_busy && (r_cnt == 6'd1);
            if (i_ctl.load) begin
                r_level <= i_base;
                r_goal  <= i_goal;
                r_down  <= i_goal < i_base;
                r_diff  <= n_diff;
                r_deadline <= i_ctl.now_ms;
            end
            if (i_ctl.div_start) begin
                r_dividend <= i_ctl.seg_len;
                r_rem <= '0;
                r_cnt <= 6'(TIME_W);
                r_busy <= (n_diff != '0);
                r_period <= '0;
            end else if (r_busy) begin
                r_dividend <= {r_dividend[TIME_W-2:0], 1'b0};
                if (!n_trial[COLOR_W+1]) begin
                    r_rem <= n_trial[COLOR_W:0];
                    r_period <= {r_period[TIME_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_period <= {r_period[TIME_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
            // add period to the start time once the quotient is complete
            if (r_fix) r_deadline <= sat_add(r_deadline, r_period);
            if (i_ctl.step && r_level != r_goal && r_deadline < i_ctl.now_ms) begin
                r_level <= r_down ? r_level - 8'd1 : r_level + 8'd1;
                r_deadline <= sat_add(i_ctl.now_ms, r_period);
            end
        end
    end

    assign o_level = r_level;
    assign o_sts.div_busy = r_busy | r_fix;
    assign o_sts.at_goal  = (r_level == r_goal);
    assign o_sts.pending  = (r_level != r_goal) && !(r_deadline < i_ctl.now_ms)
                            || ((r_level != r_goal) && (r_deadline < i_ctl.now_ms)
                                && ((r_down ? r_level - 8'd1 : r_level + 8'd1) != r_goal));
endmodule

/* src/rfs_merge.sv */
// Merge lane levels and status into the displayed color and done flag.
module rfs_merge #(
    parameter int unsigned CHANNELS = 4
) (
    input  logic [CHANNELS-1:0][rfs_pkg::COLOR_W-1:0] i_level,
    input  rfs_pkg::t_lane_sts [CHANNELS-1:0]         i_sts,
    input  logic [4*rfs_pkg::COLOR_W-1:0]             i_base_color,
    input  logic [1:0]                                i_fx,
    input  logic                                      i_strobe_on,
    input  logic                                      i_time_up,
    input  logic                                      i_use_pending,
    output rfs_pkg::t_rsp                             o_rsp
);
    import rfs_pkg::*;
    logic [3:0][COLOR_W-1:0] v;
    logic grad_ok;

    always_comb begin
        grad_ok = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_use_pending ? i_sts[i].pending : !i_sts[i].at_goal) grad_ok = 1'b0;
        end
        for (int j = 0; j < 4; j++) begin
            v[j] = i_base_color[j*COLOR_W +: COLOR_W];
            if (i_fx[FX_STROBE_BIT] && !i_strobe_on) v[j] = '0;
            else if (i_fx[FX_GRADIENT_BIT] && j < CHANNELS) v[j] = i_level[j];
        end
        o_rsp.show_red   = v[0];
        o_rsp.show_green = v[1];
        o_rsp.show_blue  = v[2];
        o_rsp.show_white = v[3];
        o_rsp.segment_done = i_time_up && (!i_fx[FX_GRADIENT_BIT] || grad_ok);
    end
endmodule

/* src/rgbw_fade_strobe_engine_top.sv */
// Top level of the RGBW fade and strobe engine.
// A start item loads a segment and runs one restoring divider per channel lane in
// parallel. After the input transfer, S_LEN loads the segment and the lanes, the
// dividers derive each step period (one quotient bit per cycle), each lane adds the
// period to the deadline, S_DIV sees all lanes idle and S_EMIT registers the result;
// a lane whose channel has no fade leaves its divider idle. For an update item, S_UPD
// toggles the strobe and steps the lanes, then S_EMIT registers the result from the
// stepped state. One item is in work at a time and the next transfer is taken in
// S_IDLE after the result is registered. A result waiting in the output register
// blocks the next input transfer unless it leaves in the same cycle.
module rgbw_fade_strobe_engine_top #(
    parameter int unsigned CHANNELS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rfs_if.sink                            s_in,
    rfs_if.source                          m_out
);
    import rfs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LEN, S_DIV, S_UPD, S_EMIT} t_state;

    t_state r_state;
    logic [SCALE_W-1:0] r_scale;
    logic [SPER_W-1:0]  r_sper;
    t_req               r_req;
    logic [TIME_W-1:0]  r_seg_start, r_seg_len, r_strobe_mark;
    logic [1:0]         r_fx;
    logic [4*COLOR_W-1:0] r_base_color;
    logic               r_strobe_on, r_use_pending;
    logic               r_out_valid;
    t_rsp               r_out;
    t_lane_ctl          n_ctl;
    t_lane_sts [CHANNELS-1:0] w_sts;
    logic [CHANNELS-1:0][COLOR_W-1:0] w_level;
    logic [CHANNELS-1:0] w_busy;
    logic [3:0][COLOR_W-1:0] w_base, w_goal;
    t_rsp               w_rsp;
    logic               w_time_up;
    logic [TIME_W:0]    w_end;

    assign w_base = {r_req.base_white, r_req.base_blue, r_req.base_green, r_req.base_red};
    assign w_goal = {r_req.goal_white, r_req.goal_blue, r_req.goal_green, r_req.goal_red};

    // accept only when idle and the output register is free or draining
    assign s_in.ready = (r_state == S_IDLE) && (!r_out_valid || m_out.ready);

    always_comb begin
        n_ctl.load      = (r_state == S_LEN);
        n_ctl.div_start = (r_state == S_LEN);
        n_ctl.step      = (r_state == S_UPD) && r_fx[FX_GRADIENT_BIT];
        n_ctl.now_ms    = r_req.now_ms;
        n_ctl.seg_len   = {16'b0, r_req.segment_time} * {22'b0, r_scale};
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        rfs_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (n_ctl),
            .i_base (g < 4 ? w_base[g % 4] : '0),
            .i_goal (g < 4 ? w_goal[g % 4] : '0),
            .o_level(w_level[g]),
            .o_sts  (w_sts[g])
        );
        assign w_busy[g] = w_sts[g].div_busy;
    end

    assign w_end = {1'b0, r_seg_start} + {1'b0, r_seg_len};
    assign w_time_up = {1'b0, r_req.now_ms} >= w_end;

    rfs_merge #(.CHANNELS(CHANNELS)) u_merge (
        .i_level      (w_level),
        .i_sts        (w_sts),
        .i_base_color (r_base_color),
        .i_fx         (r_fx),
        .i_strobe_on  (r_strobe_on),
        .i_time_up    (w_time_up),
        .i_use_pending(r_use_pending),
        .o_rsp        (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scale <= SCALE_W'(10);
            r_sper  <= SPER_W'(100);
            r_seg_start <= '0; r_seg_len <= '0; r_strobe_mark <= '0;
            r_fx <= '0; r_base_color <= '0; r_strobe_on <= 1'b0;
            r_use_pending <= 1'b0; r_out_valid <= 1'b0;
            r_req <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TIME_SCALE:    r_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_STROBE_PERIOD: r_sper  <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop the held result once it transfers
            if (m_out.valid && m_out.ready && r_state != S_EMIT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_in.valid && s_in.ready) begin
                    // hold the item; fork on request type
                    r_req <= s_in.data;
                    r_state <= (s_in.data.req_type == REQ_START) ? S_LEN : S_UPD;
                end
                S_LEN: begin
                    r_seg_start <= r_req.now_ms;
                    r_seg_len <= n_ctl.seg_len;
                    r_fx <= r_req.effect_flags;
                    r_base_color <= w_base;
                    r_strobe_mark <= r_req.now_ms;
                    r_strobe_on <= 1'b1;
                    r_use_pending <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: if (w_busy == '0) r_state <= S_EMIT;
                S_UPD: begin
                    // toggle the strobe and step the lanes; the result follows next cycle
                    if (r_fx[FX_STROBE_BIT] && ({1'b0, r_req.now_ms} >=
                        {1'b0, r_strobe_mark} + {17'b0, r_sper})) begin
                        r_strobe_on <= !r_strobe_on;
                        r_strobe_mark <= r_req.now_ms;
                    end
                    r_use_pending <= 1'b0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // register color and done flag from the settled state
                    r_out <= w_rsp;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_out;
endmodule
